// ===== hw/rtl/pect_pkg.sv =====
`default_nettype none
package pect_pkg;
	localparam int MaxVertices = 64;
	localparam int IdxW        = 6;
	localparam int CntW        = 7;
	localparam int CoordW      = 24;
	localparam int DiffW       = CoordW + 1;
	localparam int ProdW       = 2 * DiffW;
	localparam int CrossW      = ProdW + 1;
	localparam int AccW        = CrossW + IdxW;
	localparam int EpsW        = 20;
	localparam int StatusW     = 2;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [DiffW-1:0]  diff_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [CrossW-1:0] cross_t;
	typedef logic signed [AccW-1:0]   acc_t;
	typedef logic [IdxW-1:0]          idx_t;
	typedef logic [CntW-1:0]          cnt_t;
	typedef logic [StatusW-1:0]       status_t;

	localparam status_t ST_TRI   = 2'd0;
	localparam status_t ST_SHORT = 2'd1;
	localparam status_t ST_NOEAR = 2'd2;
	localparam status_t ST_OVF   = 2'd3;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		point_t pt;
		idx_t   lbl;
	} vtx_t;

	// ring operation applied to every cell in the same cycle
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_ROT  = 2'd1,
		OP_DEL  = 2'd2,
		OP_FLIP = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     load_en;
		logic     is_last;
		logic     is_head;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		K_AREA    = 2'd0,
		K_CONVEX  = 2'd1,
		K_CONTAIN = 2'd2
	} kind_t;

	typedef struct packed {
		logic  vld;
		kind_t kind;
	} tag_t;
endpackage
`default_nettype wire

// ===== hw/rtl/pect_cell.sv =====
`default_nettype none
module pect_cell (
	input  wire logic               clk,
	input  wire pect_pkg::cell_ctl_t ctl,
	input  wire pect_pkg::point_t   load_pt,
	input  wire pect_pkg::idx_t     load_lbl,
	input  wire pect_pkg::vtx_t     nxt,
	input  wire pect_pkg::vtx_t     wrap,
	input  wire pect_pkg::idx_t     last_lbl,
	output pect_pkg::vtx_t          q
);
	pect_pkg::vtx_t v_q;

	always_ff @(posedge clk) begin
		if (ctl.load_en) begin
			v_q.pt  <= load_pt;
			v_q.lbl <= load_lbl;
		end else begin
			case (ctl.op)
				pect_pkg::OP_ROT: begin
					v_q <= ctl.is_last ? wrap : nxt;
				end
				pect_pkg::OP_DEL: begin
					// head cell stays, the rest close the gap at cell 1
					if (!ctl.is_head) begin
						v_q <= nxt;
					end
				end
				pect_pkg::OP_FLIP: begin
					v_q.lbl <= last_lbl - v_q.lbl;
				end
				default: begin
				end
			endcase
		end
	end

	assign q = v_q;
endmodule
`default_nettype wire

// ===== hw/rtl/pect_cross.sv =====
`default_nettype none
module pect_cross (
	input  wire logic             clk,
	input  wire pect_pkg::point_t a,
	input  wire pect_pkg::point_t b,
	input  wire pect_pkg::point_t p,
	output pect_pkg::cross_t      cr
);
	// (b - a) x (p - a), two register stages
	pect_pkg::diff_t bx_s1, by_s1, px_s1, py_s1;
	pect_pkg::prod_t m1_s2, m2_s2;

	always_ff @(posedge clk) begin
		bx_s1 <= pect_pkg::diff_t'(b.x) - pect_pkg::diff_t'(a.x);
		by_s1 <= pect_pkg::diff_t'(b.y) - pect_pkg::diff_t'(a.y);
		px_s1 <= pect_pkg::diff_t'(p.x) - pect_pkg::diff_t'(a.x);
		py_s1 <= pect_pkg::diff_t'(p.y) - pect_pkg::diff_t'(a.y);
		m1_s2 <= pect_pkg::prod_t'(bx_s1) * pect_pkg::prod_t'(py_s1);
		m2_s2 <= pect_pkg::prod_t'(by_s1) * pect_pkg::prod_t'(px_s1);
	end

	assign cr = pect_pkg::cross_t'(m1_s2) - pect_pkg::cross_t'(m2_s2);
endmodule
`default_nettype wire

// ===== hw/rtl/polygon_ear_clip_triangulator_unit.sv =====
// Load: one vertex beat per cycle; the final vertex starts the run.
// Run: an area pass over the ring, then per ear candidate a convexity probe
// and one ring sweep through the cross lanes, plus ring rotations to align;
// errors are answered from the error state once the output register is free.
// One polygon at a time; the next load begins once the run_end beat is issued.
// Reset (arst_n low): control, counters and ear_epsilon clear; vertex cells hold junk.
`default_nettype none
module polygon_ear_clip_triangulator_unit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// vertex channel
	input  wire logic                   vertex_valid,
	output logic                        vertex_ready,
	input  wire logic signed [23:0]     vertex_x,
	input  wire logic signed [23:0]     vertex_y,
	input  wire logic                   final_vertex,
	// triangle channel
	output logic                        tri_valid,
	input  wire logic                   tri_ready,
	output logic [5:0]                  corner_a,
	output logic [5:0]                  corner_b,
	output logic [5:0]                  corner_c,
	output logic                        order_reversed,
	output logic [1:0]                  status,
	output logic                        run_end,
	// register port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	localparam int NV = pect_pkg::MaxVertices;

	typedef enum logic [10:0] {
		S_LOAD   = 11'b000_0000_0001,
		S_AREA   = 11'b000_0000_0010,
		S_ADRAIN = 11'b000_0000_0100,
		S_ORIENT = 11'b000_0000_1000,
		S_ALIGN  = 11'b000_0001_0000,
		S_PICK   = 11'b000_0010_0000,
		S_SWEEP  = 11'b000_0100_0000,
		S_CDRAIN = 11'b000_1000_0000,
		S_DECIDE = 11'b001_0000_0000,
		S_STEP   = 11'b010_0000_0000,
		S_ERR    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	// ---------------- register port ----------------
	logic [pect_pkg::EpsW-1:0] eps_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			eps_q <= pwdata[pect_pkg::EpsW-1:0];
		end
	end
	assign prdata = paddr[2] ? 32'd0 : 32'(eps_q);

	// ---------------- control registers ----------------
	pect_pkg::cnt_t ld_cnt_q, len_q, cnt_q, cand_q;
	logic ovf_q, rev_q, convex_q, blocked_q;
	pect_pkg::status_t err_q;
	pect_pkg::acc_t acc_q;
	pect_pkg::vtx_t tp_q, tc_q, tq_q;   // candidate triangle: prev, ear, next
	pect_pkg::tag_t tag_s1, tag_s2;

	// ---------------- cell row ----------------
	pect_pkg::vtx_t cell_v [NV];
	pect_pkg::cell_ctl_t cell_ctl [NV];
	pect_pkg::cell_op_t op;
	pect_pkg::cnt_t len_m1;
	logic ld_fire, in_beat;
	pect_pkg::point_t load_pt;

	assign in_beat = vertex_valid && vertex_ready;
	assign ld_fire = in_beat && !ld_cnt_q[pect_pkg::CntW-1];
	assign len_m1  = len_q - pect_pkg::cnt_t'(1);
	assign load_pt.x = vertex_x;
	assign load_pt.y = vertex_y;

	for (genvar i = 0; i < NV; i++) begin : g_cell
		assign cell_ctl[i].op      = op;
		assign cell_ctl[i].load_en = ld_fire && (ld_cnt_q == pect_pkg::cnt_t'(i));
		assign cell_ctl[i].is_last = (len_m1 == pect_pkg::cnt_t'(i));
		assign cell_ctl[i].is_head = (i == 0);
		pect_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[i]),
			.load_pt  (load_pt),
			.load_lbl (ld_cnt_q[pect_pkg::IdxW-1:0]),
			.nxt      (cell_v[(i + 1) % NV]),
			.wrap     (cell_v[0]),
			.last_lbl (len_m1[pect_pkg::IdxW-1:0]),
			.q        (cell_v[i])
		);
	end

	// ring neighbors of the cell-1 candidate, in label order
	pect_pkg::vtx_t c0, c1, c2, nb_prev, nb_next;
	assign c0 = cell_v[0];
	assign c1 = cell_v[1];
	assign c2 = cell_v[2];
	assign nb_prev = rev_q ? c2 : c0;
	assign nb_next = rev_q ? c0 : c2;

	logic at_head;
	assign at_head = rev_q ? (c1.lbl < c2.lbl) : (c1.lbl < c0.lbl);

	// ---------------- cross lanes ----------------
	pect_pkg::point_t l0_a, l0_b, l0_p, l1_a, l1_b, l2_a, l2_b;
	pect_pkg::cross_t cr0, cr1, cr2;

	always_comb begin
		l0_a = tp_q.pt;
		l0_b = tc_q.pt;
		l0_p = c0.pt;
		if (state_q == S_AREA) begin
			// shoelace term: origin, v[k], v[k+1]
			l0_a = '0;
			l0_b = c0.pt;
			l0_p = c1.pt;
		end else if (state_q == S_PICK) begin
			// convexity probe on the fresh candidate
			l0_a = nb_prev.pt;
			l0_b = c1.pt;
			l0_p = nb_next.pt;
		end
	end
	assign l1_a = tc_q.pt;
	assign l1_b = tq_q.pt;
	assign l2_a = tq_q.pt;
	assign l2_b = tp_q.pt;

	pect_cross u_lane0 (.clk(clk), .a(l0_a), .b(l0_b), .p(l0_p), .cr(cr0));
	pect_cross u_lane1 (.clk(clk), .a(l1_a), .b(l1_b), .p(c0.pt), .cr(cr1));
	pect_cross u_lane2 (.clk(clk), .a(l2_a), .b(l2_b), .p(c0.pt), .cr(cr2));

	logic neg_any, pos_any, inside_hit, convex_now;
	assign neg_any = cr0[pect_pkg::CrossW-1] || cr1[pect_pkg::CrossW-1]
		|| cr2[pect_pkg::CrossW-1];
	assign pos_any = (!cr0[pect_pkg::CrossW-1] && (cr0 != '0))
		|| (!cr1[pect_pkg::CrossW-1] && (cr1 != '0))
		|| (!cr2[pect_pkg::CrossW-1] && (cr2 != '0));
	assign inside_hit = !(neg_any && pos_any);   // boundary counts as inside
	assign convex_now = cr0 > pect_pkg::cross_t'(eps_q);

	// sweep point is one of the triangle's own corners
	logic self_hit;
	assign self_hit = (c0.lbl == tp_q.lbl) || (c0.lbl == tc_q.lbl) || (c0.lbl == tq_q.lbl);

	logic pipe_empty;
	assign pipe_empty = !tag_s1.vld && !tag_s2.vld;

	// ---------------- output register ----------------
	logic out_free, emit;
	pect_pkg::idx_t em_a, em_b, em_c;
	logic em_rev, em_end;
	pect_pkg::status_t em_st;
	assign out_free = !tri_valid || tri_ready;

	// ---------------- sequencer ----------------
	pect_pkg::tag_t issue;
	pect_pkg::cnt_t ld_next, step_m1;
	logic ovf_now;
	assign ld_next = ld_cnt_q + pect_pkg::cnt_t'(1);
	assign ovf_now = ovf_q || ld_cnt_q[pect_pkg::CntW-1];
	assign step_m1 = rev_q ? (len_q - pect_pkg::cnt_t'(2)) : '0;

	always_comb begin
		state_d    = state_q;
		op         = pect_pkg::OP_HOLD;
		issue.vld  = 1'b0;
		issue.kind = pect_pkg::K_AREA;
		emit       = 1'b0;
		em_a       = '0;
		em_b       = '0;
		em_c       = '0;
		em_rev     = 1'b0;
		em_st      = pect_pkg::ST_TRI;
		em_end     = 1'b0;
		case (state_q)
			S_LOAD: begin
				if (in_beat && final_vertex) begin
					if (ovf_now) begin
						state_d = S_ERR;
					end else if (ld_next < pect_pkg::cnt_t'(3)) begin
						state_d = S_ERR;
					end else begin
						state_d = S_AREA;
					end
				end
			end
			S_AREA: begin
				op        = pect_pkg::OP_ROT;
				issue.vld = 1'b1;
				if (cnt_q == len_m1) begin
					state_d = S_ADRAIN;
				end
			end
			S_ADRAIN: begin
				if (pipe_empty) begin
					state_d = S_ORIENT;
				end
			end
			S_ORIENT: begin
				if (acc_q[pect_pkg::AccW-1]) begin
					op = pect_pkg::OP_FLIP;
				end
				state_d = S_ALIGN;
			end
			S_ALIGN: begin
				if (!at_head) begin
					op = pect_pkg::OP_ROT;
				end else if (len_q == pect_pkg::cnt_t'(3)) begin
					if (out_free) begin
						emit    = 1'b1;
						em_a    = c1.lbl;
						em_b    = nb_next.lbl;
						em_c    = nb_prev.lbl;
						em_rev  = rev_q;
						em_end  = 1'b1;
						state_d = S_LOAD;
					end
				end else begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				issue.vld  = 1'b1;
				issue.kind = pect_pkg::K_CONVEX;
				state_d    = S_SWEEP;
			end
			S_SWEEP: begin
				op         = pect_pkg::OP_ROT;
				issue.vld  = !self_hit;
				issue.kind = pect_pkg::K_CONTAIN;
				if (cnt_q == len_m1) begin
					state_d = S_CDRAIN;
				end
			end
			S_CDRAIN: begin
				if (pipe_empty) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (convex_q && !blocked_q) begin
					if (out_free) begin
						emit    = 1'b1;
						em_a    = tp_q.lbl;
						em_b    = tc_q.lbl;
						em_c    = tq_q.lbl;
						em_rev  = rev_q;
						op      = pect_pkg::OP_DEL;
						state_d = S_ALIGN;
					end
				end else if (cand_q == len_m1) begin
					if (out_free) begin
						emit    = 1'b1;
						em_rev  = rev_q;
						em_st   = pect_pkg::ST_NOEAR;
						em_end  = 1'b1;
						state_d = S_LOAD;
					end
				end else begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				op = pect_pkg::OP_ROT;
				if (cnt_q == step_m1) begin
					state_d = S_PICK;
				end
			end
			S_ERR: begin
				if (out_free) begin
					emit    = 1'b1;
					em_st   = err_q;
					em_end  = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	assign vertex_ready = (state_q == S_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			ld_cnt_q  <= '0;
			ovf_q     <= 1'b0;
			len_q     <= '0;
			cnt_q     <= '0;
			cand_q    <= '0;
			rev_q     <= 1'b0;
			convex_q  <= 1'b0;
			blocked_q <= 1'b0;
			err_q     <= pect_pkg::ST_TRI;
			acc_q     <= '0;
			tag_s1    <= '0;
			tag_s2    <= '0;
			tri_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			tag_s1  <= issue;
			tag_s2  <= tag_s1;

			if (in_beat) begin
				if (ld_fire) begin
					ld_cnt_q <= ld_next;
				end else begin
					ovf_q <= 1'b1;
				end
				if (final_vertex) begin
					ld_cnt_q <= '0;
					ovf_q    <= 1'b0;
					rev_q    <= 1'b0;
					acc_q    <= '0;
					cnt_q    <= '0;
					cand_q   <= '0;
					len_q    <= ld_fire ? ld_next : ld_cnt_q;
					err_q    <= ovf_now ? pect_pkg::ST_OVF : pect_pkg::ST_SHORT;
				end
			end

			// rotation counter for area pass, sweep and candidate step
			if (state_q == S_AREA || state_q == S_SWEEP || state_q == S_STEP) begin
				cnt_q <= (state_d == state_q) ? cnt_q + pect_pkg::cnt_t'(1) : '0;
			end
			if (state_q == S_PICK) begin
				cnt_q     <= '0;
				blocked_q <= 1'b0;
			end
			if (state_q == S_ORIENT) begin
				rev_q <= acc_q[pect_pkg::AccW-1];
			end
			if (state_q == S_DECIDE) begin
				if (op == pect_pkg::OP_DEL) begin
					len_q  <= len_m1;
					cand_q <= '0;
				end else if (state_d == S_STEP) begin
					cand_q <= cand_q + pect_pkg::cnt_t'(1);
					cnt_q  <= '0;
				end
			end

			if (tag_s2.vld) begin
				case (tag_s2.kind)
					pect_pkg::K_AREA:    acc_q <= acc_q + pect_pkg::acc_t'(cr0);
					pect_pkg::K_CONVEX:  convex_q <= convex_now;
					pect_pkg::K_CONTAIN: blocked_q <= blocked_q || inside_hit;
					default: begin
					end
				endcase
			end

			if (emit) begin
				tri_valid <= 1'b1;
			end else if (tri_ready) begin
				tri_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PICK) begin
			tp_q <= nb_prev;
			tc_q <= c1;
			tq_q <= nb_next;
		end
		if (emit) begin
			corner_a       <= em_a;
			corner_b       <= em_b;
			corner_c       <= em_c;
			order_reversed <= em_rev;
			status         <= em_st;
			run_end        <= em_end;
		end
	end

	// ---------------- assertions ----------------
	a_ring_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALIGN || state_q == S_PICK || state_q == S_SWEEP
			|| state_q == S_DECIDE || state_q == S_STEP) |-> len_q >= pect_pkg::cnt_t'(3))
		else $error("ring shorter than a triangle during clipping");

	a_tag_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s2.vld |-> $past(tag_s1.vld))
		else $error("lane result without issue");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> pipe_empty)
		else $error("cross lanes busy while loading");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(tri_valid && status != pect_pkg::ST_TRI) |->
			(run_end && corner_a == '0 && corner_b == '0 && corner_c == '0))
		else $error("error beat with corners or without run_end");
endmodule
`default_nettype wire

// ===== sim/tb_polygon_ear_clip_triangulator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_polygon_ear_clip_triangulator_unit;
	import pect_pkg::*;

	// idle cycles with no beat on either channel before the run is declared hung;
	// a full 64-vertex ring with heavy blocking is cubic in the ring size
	localparam int          STALL_LIMIT = 2_000_000;
	localparam logic [2:0]  EPS_ADDR    = 3'd0;
	localparam int          PHASE_BEATS = 75;

	typedef struct packed {
		idx_t    a;
		idx_t    b;
		idx_t    c;
		logic    rev;
		status_t st;
		logic    last;
	} tri_t;

	typedef struct {
		int   x;
		int   y;
		bit   fin;
		bit   typed;
		tri_t want;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               vertex_valid = 1'b0;
	logic               vertex_ready;
	logic signed [23:0] vertex_x = '0;
	logic signed [23:0] vertex_y = '0;
	logic               final_vertex = 1'b0;
	logic               tri_valid;
	logic               tri_ready;
	logic [5:0]         corner_a, corner_b, corner_c;
	logic               order_reversed;
	logic [1:0]         status;
	logic               run_end;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	always #5 clk = ~clk;

	polygon_ear_clip_triangulator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.vertex_valid(vertex_valid), .vertex_ready(vertex_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .final_vertex(final_vertex),
		.tri_valid(tri_valid), .tri_ready(tri_ready),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.order_reversed(order_reversed), .status(status), .run_end(run_end),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// ---------------------------------------------------------------
	// Triangulation predictor: own copy of the vertex store, counters
	// and epsilon. Exact 64-bit math is enough: cross terms are 51 bits,
	// the area sum stays below 58 bits.
	// ---------------------------------------------------------------
	longint vx [MaxVertices];
	longint vy [MaxVertices];
	int     nload;
	bit     ovf_flag;
	longint eps_val;

	tri_t   pending_tris[$];   // triangles still owed by the block
	int     fail_count;
	bit     fast_in, fast_out; // no-idle stretches on either side

	function automatic tri_t mk_tri(int a, int b, int c, bit rev, status_t st, bit last);
		tri_t r;
		r.a = idx_t'(a);
		r.b = idx_t'(b);
		r.c = idx_t'(c);
		r.rev = rev;
		r.st = st;
		r.last = last;
		return r;
	endfunction

	function automatic longint cross_of(int a, int b, int c);
		return (vx[b] - vx[a]) * (vy[c] - vy[a]) - (vy[b] - vy[a]) * (vx[c] - vx[a]);
	endfunction

	function automatic int sgn(longint v);
		return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
	endfunction

	// boundary counts as inside
	function automatic bit covers(int p, int a, int b, int c);
		int s1, s2, s3;
		s1 = sgn(cross_of(a, b, p));
		s2 = sgn(cross_of(b, c, p));
		s3 = sgn(cross_of(c, a, p));
		return !((s1 < 0 || s2 < 0 || s3 < 0) && (s1 > 0 || s2 > 0 || s3 > 0));
	endfunction

	task automatic triangulate_step(input longint x, input longint y, input bit fin,
			output tri_t outs[$]);
		int     n, len, li, t, p, c, q, v, i, j;
		bit     rev, found, blocked;
		longint area, tmp;
		int     ring[$];
		outs = {};
		if (nload < MaxVertices) begin
			vx[nload] = x;
			vy[nload] = y;
			nload++;
		end else
			ovf_flag = 1'b1;
		if (!fin)
			return;
		n = nload;
		nload = 0;
		if (ovf_flag) begin
			ovf_flag = 1'b0;
			outs.push_back(mk_tri(0, 0, 0, 0, ST_OVF, 1));
			return;
		end
		if (n < 3) begin
			outs.push_back(mk_tri(0, 0, 0, 0, ST_SHORT, 1));
			return;
		end
		area = 0;
		for (i = 0; i < n; i++) begin
			j = (i + 1) % n;
			area += vx[i] * vy[j] - vx[j] * vy[i];
		end
		// clockwise ring is flipped so indices follow CCW order
		rev = (area < 0);
		if (rev) begin
			for (i = 0; i < n / 2; i++) begin
				j = n - 1 - i;
				tmp = vx[i]; vx[i] = vx[j]; vx[j] = tmp;
				tmp = vy[i]; vy[i] = vy[j]; vy[j] = tmp;
			end
		end
		for (i = 0; i < n; i++)
			ring.push_back(i);
		while (ring.size() > 3) begin
			len = ring.size();
			found = 1'b0;
			for (li = 0; li < len && !found; li++) begin
				p = ring[(li + len - 1) % len];
				c = ring[li];
				q = ring[(li + 1) % len];
				if (cross_of(p, c, q) <= eps_val)
					continue;
				blocked = 1'b0;
				for (t = 0; t < len && !blocked; t++) begin
					v = ring[t];
					if (v == p || v == c || v == q)
						continue;
					blocked = covers(v, p, c, q);
				end
				if (!blocked) begin
					outs.push_back(mk_tri(p, c, q, rev, ST_TRI, 0));
					ring.delete(li);
					found = 1'b1;
				end
			end
			if (!found) begin
				// partial triangles stay queued ahead of the no-ear beat
				outs.push_back(mk_tri(0, 0, 0, rev, ST_NOEAR, 1));
				return;
			end
		end
		outs.push_back(mk_tri(ring[0], ring[1], ring[2], rev, ST_TRI, 1));
	endtask

	// ---------------------------------------------------------------
	// Vertex channel. Gap is drawn before each beat; valid is only
	// lowered when a gap is taken, so it is never dropped and raised
	// within one step.
	// ---------------------------------------------------------------
	task automatic send_vertex(input int x, input int y, input bit fin,
			input bit typed, input tri_t want);
		int   gap;
		tri_t got[$];
		gap = fast_in ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			vertex_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vertex_x <= x[23:0];
		vertex_y <= y[23:0];
		final_vertex <= fin;
		vertex_valid <= 1'b1;
		do @(posedge clk); while (!(vertex_valid && vertex_ready));
		triangulate_step(longint'($signed(x[23:0])), longint'($signed(y[23:0])), fin, got);
		// typed rows carry their answer; predictor still runs to keep state aligned
		if (typed)
			pending_tris.push_back(want);
		else
			foreach (got[k])
				pending_tris.push_back(got[k]);
	endtask

	// wait until every owed triangle has come back, then let the block settle
	task automatic drain();
		vertex_valid <= 1'b0;
		while (pending_tris.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// register write: setup phase, then access phase until pready
	task automatic write_eps(input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= EPS_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		eps_val = longint'(value[EpsW-1:0]);
	endtask

	// polygon shapes: 0 star-shaped ring, 1 random points, 2 collinear/duplicate
	task automatic send_polygon(input int shape, input int n);
		int  xs[$], ys[$];
		int  rad_max, span, cx, cy, bx, by, dx, dy, k, i;
		real th, rr;
		bit  cw;
		rad_max = 1 << $urandom_range(4, 22);
		span = 8388600 - rad_max;
		cx = int'($urandom_range(0, 2 * span)) - span;
		cy = int'($urandom_range(0, 2 * span)) - span;
		bx = int'($urandom_range(0, 2000)) - 1000;
		by = int'($urandom_range(0, 2000)) - 1000;
		dx = int'($urandom_range(0, 64)) - 32;
		dy = int'($urandom_range(0, 64)) - 32;
		for (i = 0; i < n; i++) begin
			case (shape)
				0: begin
					th = (i + 0.8 * $urandom_range(0, 1000) / 1000.0) * 6.2831853 / n;
					rr = rad_max * (0.3 + 0.7 * $urandom_range(0, 1000) / 1000.0);
					xs.push_back(cx + $rtoi(rr * $cos(th)));
					ys.push_back(cy + $rtoi(rr * $sin(th)));
				end
				1: begin
					xs.push_back(int'($signed($urandom() & 32'h00FF_FFFF) << 8) >>> 8);
					ys.push_back(int'($signed($urandom() & 32'h00FF_FFFF) << 8) >>> 8);
				end
				default: begin
					k = $urandom_range(0, 3);
					xs.push_back(bx + k * dx);
					ys.push_back(by + k * dy);
				end
			endcase
		end
		cw = $urandom_range(0, 1);
		for (i = 0; i < n; i++) begin
			k = cw ? n - 1 - i : i;
			send_vertex(xs[k], ys[k], i == n - 1, 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------
	// Triangle channel: scoreboard and ready stalls
	// ---------------------------------------------------------------
	int   ready_hold;
	tri_t seen;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_ready <= 1'b0;
			ready_hold <= 0;
		end else if (tri_valid && tri_ready) begin
			seen = mk_tri(corner_a, corner_b, corner_c, order_reversed, status, run_end);
			if (pending_tris.size() == 0) begin
				$display("%0t: unexpected beat a=%0d b=%0d c=%0d rev=%0d st=%0d end=%0d",
					$time, seen.a, seen.b, seen.c, seen.rev, seen.st, seen.last);
				fail_count++;
			end else begin
				if (seen !== pending_tris[0]) begin
					$display("%0t: mismatch exp a=%0d b=%0d c=%0d rev=%0d st=%0d end=%0d",
						$time, pending_tris[0].a, pending_tris[0].b, pending_tris[0].c,
						pending_tris[0].rev, pending_tris[0].st, pending_tris[0].last);
					$display("%0t:          got a=%0d b=%0d c=%0d rev=%0d st=%0d end=%0d",
						$time, seen.a, seen.b, seen.c, seen.rev, seen.st, seen.last);
					fail_count++;
				end
				void'(pending_tris.pop_front());
			end
			ready_hold = fast_out ? 0 : $urandom_range(0, 4);
			if (ready_hold > 0)
				tri_ready <= 1'b0;
		end else if (!tri_ready) begin
			if (ready_hold <= 1)
				tri_ready <= 1'b1;
			ready_hold = ready_hold - 1;
		end
	end

	// watchdog on cycles with no beat at all
	int stall_cycles = 0;
	always @(posedge clk) begin
		if ((vertex_valid && vertex_ready) || (tri_valid && tri_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	dir_row_t dir_rows[$];

	task automatic add_row(input int x, input int y, input bit fin,
			input bit typed, input tri_t want);
		dir_row_t r;
		r.x = x;
		r.y = y;
		r.fin = fin;
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endtask

	initial begin
		int   ph, sent, pick, n;
		tri_t none;
		fail_count = 0;
		nload = 0;
		ovf_flag = 1'b0;
		eps_val = 0;
		fast_in = 1'b0;
		fast_out = 1'b0;
		none = '0;

		// lone vertex, then a pair at opposite extremes: too few vertices
		add_row(0, 0, 1, 1, mk_tri(0, 0, 0, 0, ST_SHORT, 1));
		add_row(-8388608, 8388607, 0, 0, none);
		add_row(8388607, -8388608, 1, 1, mk_tri(0, 0, 0, 0, ST_SHORT, 1));
		// full-range CCW triangle
		add_row(-8388608, -8388608, 0, 0, none);
		add_row(8388607, -8388608, 0, 0, none);
		add_row(8388607, 8388607, 1, 1, mk_tri(0, 1, 2, 0, ST_TRI, 1));
		// full-range CW triangle: flipped
		add_row(-8388608, -8388608, 0, 0, none);
		add_row(8388607, 8388607, 0, 0, none);
		add_row(8388607, -8388608, 1, 1, mk_tri(0, 1, 2, 1, ST_TRI, 1));
		// zero area triangle stays unflipped
		add_row(0, 0, 0, 0, none);
		add_row(16, 16, 0, 0, none);
		add_row(32, 32, 1, 1, mk_tri(0, 1, 2, 0, ST_TRI, 1));
		// four collinear points: no convex corner anywhere
		add_row(0, 0, 0, 0, none);
		add_row(16, 0, 0, 0, none);
		add_row(32, 0, 0, 0, none);
		add_row(48, 0, 1, 1, mk_tri(0, 0, 0, 0, ST_NOEAR, 1));
		// square and a concave pentagon
		add_row(0, 0, 0, 0, none);
		add_row(160, 0, 0, 0, none);
		add_row(160, 160, 0, 0, none);
		add_row(0, 160, 1, 0, none);
		add_row(0, 0, 0, 0, none);
		add_row(100, 0, 0, 0, none);
		add_row(50, 20, 0, 0, none);
		add_row(100, 100, 0, 0, none);
		add_row(0, 100, 1, 0, none);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fin,
				dir_rows[i].typed, dir_rows[i].want);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			// epsilon: zero with junk above bit 19, max, small, fully random
			case (ph)
				0: write_eps(32'hFFF0_0000);
				1: write_eps(32'h000F_FFFF);
				2: write_eps($urandom_range(1, 5000));
				default: write_eps($urandom());
			endcase
			sent = 0;
			while (sent < PHASE_BEATS) begin
				fast_in = ($urandom_range(0, 3) == 0);
				fast_out = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					n = $urandom_range(1, 2);
					send_polygon(1, n);
				end else if (pick < 70) begin
					n = $urandom_range(3, 10);
					send_polygon(0, n);
				end else if (pick < 85) begin
					n = $urandom_range(3, 8);
					send_polygon(1, n);
				end else if (pick < 95) begin
					n = $urandom_range(4, 7);
					send_polygon(2, n);
				end else begin
					n = $urandom_range(11, 16);
					send_polygon(0, n);
				end
				sent += n;
				// sender holds off until the block has answered everything
				if ($urandom_range(0, 9) == 0)
					drain();
			end
			// one big ring per phase: full store, overflow, dense noise, mid-size
			case (ph)
				0: send_polygon(0, MaxVertices);
				1: send_polygon(1, $urandom_range(MaxVertices + 1, MaxVertices + 3));
				2: send_polygon(1, MaxVertices);
				default: send_polygon(0, 40);
			endcase
			drain();
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
